/* rtl/nnfs_pkg.sv */
// shared types and constants of the nearest-neighbour frame scaler
`default_nettype none
package nnfs_pkg;

  localparam int STORE_AW = 16;
  localparam int PIX_W    = 24;
  localparam int CRD_W    = 12;
  localparam int SIZE_W   = 13;
  localparam int PROD_W   = 25;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_FETCH = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SCALE_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] src_index;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] dst_x;
    logic [11:0] dst_y;
  } req_t;

  typedef struct packed {
    logic [23:0] rgb_pixel;
    logic        out_of_range;
  } res_t;

  // clamped sizes and mode
  typedef struct packed {
    logic [SIZE_W-1:0] sw;
    logic [SIZE_W-1:0] sh;
    logic [CRD_W-1:0]  dw;
    logic [CRD_W-1:0]  dh;
    logic              scale;
  } cfg_t;

  typedef struct packed {
    req_kind_t           kind;
    logic                oor;
    logic [CRD_W-1:0]    sx;
    logic [CRD_W-1:0]    sy;
    logic [STORE_AW-1:0] addr;
    logic [PIX_W-1:0]    pixel;
  } job_t;

endpackage
`default_nettype wire

/* rtl/nearest_neighbor_frame_scaler.sv */
// top level: register file, front end, queue and back end
// stages: input register, NQ divider stages (NQ = ceil(log2) of the larger maximum source
// size, 8 with default parameters, one per bit), queue, address, read and result registers
// throughput: one item per cycle, loads and fetches alike; busy stays low since the
// back end drains the queue every cycle and the receiver cannot stall
// reset: synchronous; registers return to their reset values, the frame store is not cleared
`default_nettype none
module nearest_neighbor_frame_scaler import nnfs_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int DST_COORD_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             done,
  output res_t             result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int QW  = $clog2(MAX_SRC_WIDTH);
  localparam int QH  = $clog2(MAX_SRC_HEIGHT);
  localparam int QM  = (QW > QH) ? QW : QH;
  localparam int NQ  = (QM > 0) ? QM : 1;
  localparam logic [SIZE_W-1:0] MAXW = SIZE_W'(MAX_SRC_WIDTH);
  localparam logic [SIZE_W-1:0] MAXH = SIZE_W'(MAX_SRC_HEIGHT);

  logic [8:0]  src_width;
  logic [8:0]  src_height;
  logic [11:0] dst_width;
  logic [11:0] dst_height;
  logic        scale_mode;
  cfg_t        cfg;
  reg_idx_t    idx;

  logic accept;
  logic push;
  job_t job;
  logic pop;
  job_t head;
  logic empty;
  logic full;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 9'd256;
      src_height <= 9'd256;
      dst_width  <= 12'd256;
      dst_height <= 12'd256;
      scale_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SRC_WIDTH:  src_width  <= pwdata[8:0];
        REG_SRC_HEIGHT: src_height <= pwdata[8:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[11:0];
        REG_DST_HEIGHT: dst_height <= pwdata[11:0];
        REG_SCALE_MODE: scale_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_WIDTH:  prdata = {23'd0, src_width};
      REG_SRC_HEIGHT: prdata = {23'd0, src_height};
      REG_DST_WIDTH:  prdata = {20'd0, dst_width};
      REG_DST_HEIGHT: prdata = {20'd0, dst_height};
      REG_SCALE_MODE: prdata = {31'd0, scale_mode};
      default:        prdata = '0;
    endcase
  end

  // zero sizes read as one, source sizes saturate at the store limits
  always_comb begin
    if (src_width == 9'd0) begin
      cfg.sw = SIZE_W'(1);
    end else if (SIZE_W'(src_width) > MAXW) begin
      cfg.sw = MAXW;
    end else begin
      cfg.sw = SIZE_W'(src_width);
    end
    if (src_height == 9'd0) begin
      cfg.sh = SIZE_W'(1);
    end else if (SIZE_W'(src_height) > MAXH) begin
      cfg.sh = MAXH;
    end else begin
      cfg.sh = SIZE_W'(src_height);
    end
    cfg.dw    = (dst_width == 12'd0) ? 12'd1 : dst_width;
    cfg.dh    = (dst_height == 12'd0) ? 12'd1 : dst_height;
    cfg.scale = scale_mode;
  end

  assign busy   = full;
  assign accept = start && !busy;

  nnfs_front #(
    .DST_COORD_BITS(DST_COORD_BITS),
    .NQ(NQ)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .req(req),
    .cfg(cfg),
    .push(push),
    .job(job)
  );

  nnfs_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(job),
    .pop(pop),
    .head(head),
    .empty(empty),
    .full(full)
  );

  nnfs_back u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .head(head),
    .cfg(cfg),
    .pop(pop),
    .done(done),
    .result(result)
  );

endmodule
`default_nettype wire

/* rtl/nnfs_front.sv */
// front end: classifies items, multiplies and runs the pipelined dividers
`default_nettype none
module nnfs_front import nnfs_pkg::*; #(
  parameter int DST_COORD_BITS = 12,
  parameter int NQ = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output logic      push,
  output job_t      job
);

  localparam logic [CRD_W-1:0] CMASK = (DST_COORD_BITS >= CRD_W) ? {CRD_W{1'b1}} :
                                       CRD_W'((1 << DST_COORD_BITS) - 1);

  logic              stg_valid [0:NQ];
  job_t              stg_job   [0:NQ];
  logic              stg_scale [0:NQ];
  logic [PROD_W-1:0] stg_rx    [0:NQ];
  logic [PROD_W-1:0] stg_ry    [0:NQ];

  logic [CRD_W-1:0] x;
  logic [CRD_W-1:0] y;
  logic             oor;

  always_comb begin
    x = req.dst_x & CMASK;
    y = req.dst_y & CMASK;
    oor = (x >= cfg.dw) || (y >= cfg.dh) ||
          (!cfg.scale && ((SIZE_W'(x) >= cfg.sw) || (SIZE_W'(y) >= cfg.sh)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else begin
      stg_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stg_job[0].kind  <= req_kind_t'(req.req_type);
    stg_job[0].oor   <= (req.req_type == REQ_FETCH) && oor;
    stg_job[0].sx    <= cfg.scale ? '0 : x;
    stg_job[0].sy    <= cfg.scale ? '0 : y;
    stg_job[0].addr  <= req.src_index;
    stg_job[0].pixel <= {req.red, req.green, req.blue};
    stg_scale[0]     <= cfg.scale;
    stg_rx[0]        <= PROD_W'(x) * PROD_W'(cfg.sw);
    stg_ry[0]        <= PROD_W'(y) * PROD_W'(cfg.sh);
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_div
    localparam int BIT = NQ - k;
    logic [PROD_W-1:0] dx;
    logic [PROD_W-1:0] dy;
    job_t              nj;
    logic [PROD_W-1:0] nrx;
    logic [PROD_W-1:0] nry;

    always_comb begin
      dx  = PROD_W'(cfg.dw) << BIT;
      dy  = PROD_W'(cfg.dh) << BIT;
      nj  = stg_job[k-1];
      nrx = stg_rx[k-1];
      nry = stg_ry[k-1];
      if (stg_scale[k-1]) begin
        if (stg_rx[k-1] >= dx) begin
          nrx = stg_rx[k-1] - dx;
          nj.sx[BIT] = 1'b1;
        end
        if (stg_ry[k-1] >= dy) begin
          nry = stg_ry[k-1] - dy;
          nj.sy[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else begin
        stg_valid[k] <= stg_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      stg_job[k]   <= nj;
      stg_scale[k] <= stg_scale[k-1];
      stg_rx[k]    <= nrx;
      stg_ry[k]    <= nry;
    end
  end

  assign push = stg_valid[NQ];
  assign job  = stg_job[NQ];

endmodule
`default_nettype wire

/* rtl/nnfs_queue.sv */
// two-entry queue between front and back end
`default_nettype none
module nnfs_queue import nnfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t din,
  input  wire logic pop,
  output job_t      head,
  output logic      empty,
  output logic      full
);

  job_t       slot [0:1];
  logic [1:0] count;
  logic [1:0] count_next;

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
    empty = (count == 2'd0);
    full  = (count == 2'd2);
    head  = slot[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot[0] <= (count == 2'd2) ? slot[1] : din;
      slot[1] <= din;
    end else if (push) begin
      if (count == 2'd0) begin
        slot[0] <= din;
      end else begin
        slot[1] <= din;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");

endmodule
`default_nettype wire

/* rtl/nnfs_back.sv */
// back end: address, frame store access and result register
`default_nettype none
module nnfs_back import nnfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic empty,
  input  wire job_t head,
  input  wire cfg_t cfg,
  output logic      pop,
  output logic      done,
  output res_t      result
);

  logic [PIX_W-1:0] store [0:(1 << STORE_AW)-1];

  logic                a_valid;
  job_t                a_job;
  logic [STORE_AW-1:0] a_addr;
  logic                b_fetch;
  logic                b_oor;
  logic [PIX_W-1:0]    b_q;
  logic [PROD_W-1:0]   lin;

  always_comb begin
    pop = !empty;
    lin = PROD_W'(head.sy) * PROD_W'(cfg.sw) + PROD_W'(head.sx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_fetch <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= pop;
      b_fetch <= a_valid && (a_job.kind == REQ_FETCH);
      done    <= b_fetch;
    end
  end

  always_ff @(posedge clk) begin
    a_job  <= head;
    a_addr <= (head.kind == REQ_LOAD) ? head.addr : lin[STORE_AW-1:0];
    b_oor  <= a_job.oor;
    result.rgb_pixel    <= b_oor ? '0 : b_q;
    result.out_of_range <= b_oor;
  end

  always_ff @(posedge clk) begin
    if (a_valid && (a_job.kind == REQ_LOAD)) begin
      store[a_addr] <= a_job.pixel;
    end
    b_q <= store[a_addr];
  end

  a_zero_when_oor: assert property (@(posedge clk) disable iff (rst)
    done && result.out_of_range |-> result.rgb_pixel == '0)
    else $error("out-of-range result carries a pixel");
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    a_valid && (a_job.kind == REQ_LOAD) |-> ##2 !done)
    else $error("load item produced a result");

endmodule
`default_nettype wire

/* dv/nearest_neighbor_frame_scaler_tb.sv */
// testbench of the nearest-neighbour frame scaler: directed and random loads and fetches
`default_nettype none
module nearest_neighbor_frame_scaler_tb;
  import nnfs_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  res_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nearest_neighbor_frame_scaler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // mirror of the frame store and registers
  logic [23:0] pixel_mirror [0:65535];
  bit          loaded [0:65535];
  logic [8:0]  src_w_reg, src_h_reg;
  logic [11:0] dst_w_reg, dst_h_reg;
  logic        scale_reg;

  res_t        pending_pixels [$];
  int          err_count;
  int          stall_count;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // returns 1 when the fetch reads the store, with the raster address
  function automatic bit source_address(input req_t r, output logic [15:0] addr);
    int sw, sh, dw, dh, x, y, sx, sy;
    sw = (src_w_reg == 0) ? 1 : ((src_w_reg > 256) ? 256 : src_w_reg);
    sh = (src_h_reg == 0) ? 1 : ((src_h_reg > 256) ? 256 : src_h_reg);
    dw = (dst_w_reg == 0) ? 1 : dst_w_reg;
    dh = (dst_h_reg == 0) ? 1 : dst_h_reg;
    x = r.dst_x;
    y = r.dst_y;
    addr = '0;
    if (x >= dw || y >= dh) return 1'b0;
    if (scale_reg) begin
      sx = (x * sw) / dw;
      sy = (y * sh) / dh;
    end else begin
      if (x >= sw || y >= sh) return 1'b0;
      sx = x;
      sy = y;
    end
    addr = 16'((sy * sw + sx) & 16'hFFFF);
    return 1'b1;
  endfunction

  task automatic send_item(input req_t r);
    logic [15:0] a;
    res_t        exp_pix;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    if (r.req_type == REQ_LOAD) begin
      pixel_mirror[r.src_index] = {r.red, r.green, r.blue};
      loaded[r.src_index] = 1'b1;
    end else begin
      if (source_address(r, a)) exp_pix = '{rgb_pixel: pixel_mirror[a], out_of_range: 1'b0};
      else exp_pix = '{rgb_pixel: 24'd0, out_of_range: 1'b1};
      pending_pixels.push_back(exp_pix);
    end
  endtask

  task automatic pause();
    int n, k;
    k = $urandom_range(0, 99);
    if (no_gaps || k < 55) n = 0;
    else if (k < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load_pixel(input logic [15:0] idx);
    req_t r;
    r = req_t'({$urandom, $urandom});
    r.req_type  = REQ_LOAD;
    r.src_index = idx;
    send_item(r);
    pause();
  endtask

  // loads the source pixel first when the fetch would read an empty entry
  task automatic fetch_pixel(input logic [11:0] x, input logic [11:0] y);
    req_t        r;
    logic [15:0] a;
    r = req_t'({$urandom, $urandom});
    r.req_type = REQ_FETCH;
    r.dst_x = x;
    r.dst_y = y;
    if (source_address(r, a) && !loaded[a]) load_pixel(a);
    send_item(r);
    pause();
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  begin mask = 32'h1FF; src_w_reg = value[8:0]; end
      REG_SRC_HEIGHT: begin mask = 32'h1FF; src_h_reg = value[8:0]; end
      REG_DST_WIDTH:  begin mask = 32'hFFF; dst_w_reg = value[11:0]; end
      REG_DST_HEIGHT: begin mask = 32'hFFF; dst_h_reg = value[11:0]; end
      default:        begin mask = 32'h1;   scale_reg = value[0]; end
    endcase
    if ((prdata & mask) != (value & mask))
      report($sformatf("register %s read %h, wrote %h", idx.name(), prdata, value));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int sw, input int sh, input int dw, input int dh,
                           input bit scale);
    settle();
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    reg_write(REG_SCALE_MODE, 32'(scale));
  endtask

  function automatic logic [11:0] pick_coord(input logic [11:0] size);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 12'($urandom);
    if (k == 1) return size;
    return 12'($urandom_range(0, (size == 0) ? 0 : size - 1));
  endfunction

  task automatic random_phase(input int count);
    int k;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 9);
      if (k < 2) load_pixel(16'($urandom));
      else fetch_pixel(pick_coord(dst_w_reg), pick_coord(dst_h_reg));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_crop_directed();
    load_pixel(16'hFFFF);
    load_pixel(16'h0000);
    fetch_pixel(12'd0, 12'd0);
    fetch_pixel(12'd255, 12'd255);
    fetch_pixel(12'd256, 12'd0);
    fetch_pixel(12'd0, 12'd256);
    fetch_pixel(12'd4095, 12'd4095);
    set_frame(100, 50, 200, 200, 1'b0);
    fetch_pixel(12'd99, 12'd49);
    fetch_pixel(12'd100, 12'd10);
    fetch_pixel(12'd10, 12'd50);
    fetch_pixel(12'd150, 12'd150);
    fetch_pixel(12'd200, 12'd0);
  endtask

  task automatic test_scale_directed();
    set_frame(256, 256, 4095, 4095, 1'b1);
    fetch_pixel(12'd0, 12'd0);
    fetch_pixel(12'd4094, 12'd4094);
    fetch_pixel(12'd4095, 12'd0);
    set_frame(7, 3, 1, 1, 1'b1);
    fetch_pixel(12'd0, 12'd0);
    fetch_pixel(12'd1, 12'd0);
  endtask

  task automatic test_size_extremes();
    set_frame(0, 0, 0, 0, 1'b1);
    fetch_pixel(12'd0, 12'd0);
    fetch_pixel(12'd1, 12'd1);
    set_frame(511, 300, 600, 4095, 1'b1);
    fetch_pixel(12'd599, 12'd4094);
    fetch_pixel(12'd300, 12'd2000);
    set_frame(511, 511, 4095, 4095, 1'b0);
    fetch_pixel(12'd255, 12'd255);
    fetch_pixel(12'd256, 12'd255);
  endtask

  // fetches of unloaded entries bring extra loads, so the item count runs above the rounds
  task automatic test_random();
    set_frame(256, 256, 256, 256, 1'b0);
    random_phase(140);
    set_frame(256, 256, 4095, 4095, 1'b1);
    random_phase(140);
    set_frame(13, 200, 37, 1000, 1'b1);
    random_phase(140);
    set_frame(1, 1, 4095, 1, 1'b1);
    random_phase(110);
    set_frame(300, 0, 2048, 3000, 1'b0);
    random_phase(140);
    set_frame(200, 150, 97, 4000, 1'b1);
    random_phase(180);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report("result with nothing expected");
      end else begin
        if (result.rgb_pixel != pending_pixels[0].rgb_pixel)
          report($sformatf("rgb_pixel %h, expected %h", result.rgb_pixel,
                 pending_pixels[0].rgb_pixel));
        if (result.out_of_range != pending_pixels[0].out_of_range)
          report($sformatf("out_of_range %b, expected %b", result.out_of_range,
                 pending_pixels[0].out_of_range));
        void'(pending_pixels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("nearest_neighbor_frame_scaler test failed");
      $finish;
    end
  end

  initial begin
    err_count = 0;
    stall_count = 0;
    no_gaps = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_w_reg = 9'd256;
    src_h_reg = 9'd256;
    dst_w_reg = 12'd256;
    dst_h_reg = 12'd256;
    scale_reg = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_crop_directed();
    test_scale_directed();
    test_size_extremes();
    test_random();
    settle();
    if (err_count == 0 && pending_pixels.size() == 0)
      $display("nearest_neighbor_frame_scaler test passed");
    else
      $display("nearest_neighbor_frame_scaler test failed");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/nnfs_pkg.sv
rtl/nnfs_front.sv
rtl/nnfs_queue.sv
rtl/nnfs_back.sv
rtl/nearest_neighbor_frame_scaler.sv
dv/nearest_neighbor_frame_scaler_tb.sv
